FILE: rtl/btts_pkg.sv
// btts_pkg: shared constants and codes for the ber-tlv tag search block
// no dependencies; imported by ber_tlv_tag_search

package btts_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TagW    = 24;
  localparam int unsigned LenW    = 16;
  localparam int unsigned PosW    = 17;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IdxW    = 2;

  // byte position saturates here
  localparam logic [PosW-1:0] PosMax = '1;

  // length and tag encoding bytes
  localparam logic [ByteW-1:0] ShortLenMax = 8'h7F;
  localparam logic [ByteW-1:0] LongLen1    = 8'h81;
  localparam logic [ByteW-1:0] LongLen2    = 8'h82;
  localparam logic [ByteW-1:0] TagMoreMask = 8'h1F;
  localparam logic [ByteW-1:0] TagContMask = 8'h80;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegTemplateTag = 2'd0;
  localparam logic [IdxW-1:0] RegTargetTag   = 2'd1;

  // register reset values
  localparam logic [ByteW-1:0] TemplateTagRst = 8'hFC;
  localparam logic [TagW-1:0]  TargetTagRst   = '0;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_FOUND        = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_WRONG_TMPL   = 3'd2,
    ST_BAD_OUTER    = 3'd3,
    ST_LEN_MISMATCH = 3'd4
  } status_t;

  // header fault codes
  typedef enum logic [1:0] {
    HF_NONE      = 2'd0,
    HF_TEMPLATE  = 2'd1,
    HF_OUTER_LEN = 2'd2,
    HF_EXCESS    = 2'd3
  } fault_t;

endpackage

FILE: rtl/ber_tlv_tag_search.sv
// ber_tlv_tag_search: walks a ber-tlv template one byte per beat, reports the first match
// the result beat is registered and valid in the cycle after the last byte is accepted
// throughput: one byte per cycle while in_stall is low; the parse state updates in a single pass per byte
// input is held off only when a last byte arrives while a previous result is still stalled
// reset (rst, synchronous): parse state cleared, template_tag = 0xFC, target_tag = 0
// depends on btts_pkg

module ber_tlv_tag_search
  import btts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input bytes
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ByteW-1:0]    data_byte,
  input  logic                last_byte,
  // configuration writes
  input  logic                cfg_write,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [TagW-1:0]     cfg_data,
  // results
  output logic                out_valid,
  input  logic                out_stall,
  output logic [StatusW-1:0]  status,
  output logic [TagW-1:0]     found_tag,
  output logic [PosW-1:0]     value_offset,
  output logic [LenW-1:0]     value_length
);

  typedef enum logic [3:0] {
    PH_TMPL      = 4'd0,
    PH_OLEN1     = 4'd1,
    PH_OLEN_MORE = 4'd2,
    PH_TAG1      = 4'd3,
    PH_TAG2      = 4'd4,
    PH_TAG3      = 4'd5,
    PH_ILEN1     = 4'd6,
    PH_ILEN_MORE = 4'd7,
    PH_SKIP      = 4'd8,
    PH_SKIP_CAND = 4'd9,
    PH_STOP      = 4'd10,
    PH_IGNORE    = 4'd11
  } phase_t;

  // configuration registers
  logic [ByteW-1:0] template_tag;
  logic [TagW-1:0]  target_tag;

  // parse state
  phase_t           phase, phase_next;
  fault_t           fault, fault_next;
  logic [PosW-1:0]  byte_pos, byte_pos_next;
  logic [LenW-1:0]  outer_len, outer_len_next;
  logic [TagW-1:0]  tag_acc, tag_acc_next;
  logic [LenW-1:0]  len_acc, len_acc_next;
  logic [1:0]       len_left, len_left_next;
  logic [LenW-1:0]  skip_left, skip_left_next;
  logic             match_latched, match_latched_next;
  logic [TagW-1:0]  match_tag, match_tag_next;
  logic [PosW-1:0]  match_off, match_off_next;
  logic [LenW-1:0]  match_len, match_len_next;

  logic             len_done;
  logic [LenW-1:0]  len_val;
  logic             cand;
  logic [PosW-1:0]  pos_inc;
  status_t          status_next;
  logic             in_accept;

  // hold input only when a result is stuck and this beat would make another
  assign in_stall  = out_valid && out_stall && last_byte;
  assign in_accept = in_valid && !in_stall;

  assign pos_inc = (byte_pos == PosMax) ? PosMax : byte_pos + 1'b1;

  // per-byte parse step
  always_comb begin
    phase_next         = phase;
    fault_next         = fault;
    outer_len_next     = outer_len;
    tag_acc_next       = tag_acc;
    len_acc_next       = len_acc;
    len_left_next      = len_left;
    skip_left_next     = skip_left;
    match_latched_next = match_latched;
    match_tag_next     = match_tag;
    match_off_next     = match_off;
    match_len_next     = match_len;
    byte_pos_next      = pos_inc;
    len_done           = 1'b0;
    len_val            = '0;
    cand               = 1'b0;

    // count down the inner bytes still expected by the outer length
    if (phase >= PH_TAG1 && phase <= PH_STOP && fault == HF_NONE) begin
      if (outer_len == '0) begin
        fault_next = HF_EXCESS;
      end else begin
        outer_len_next = outer_len - 1'b1;
      end
    end

    case (phase)
      PH_TMPL: begin
        if (data_byte != template_tag) begin
          fault_next = HF_TEMPLATE;
          phase_next = PH_IGNORE;
        end else begin
          phase_next = PH_OLEN1;
        end
      end
      PH_OLEN1: begin
        if (data_byte <= ShortLenMax) begin
          outer_len_next = {{(LenW-ByteW){1'b0}}, data_byte};
          phase_next     = PH_TAG1;
        end else if (data_byte == LongLen1 || data_byte == LongLen2) begin
          outer_len_next = '0;
          len_left_next  = (data_byte == LongLen1) ? 2'd1 : 2'd2;
          phase_next     = PH_OLEN_MORE;
        end else begin
          fault_next = HF_OUTER_LEN;
          phase_next = PH_IGNORE;
        end
      end
      PH_OLEN_MORE: begin
        outer_len_next = {outer_len[ByteW-1:0], data_byte};
        len_left_next  = len_left - 2'd1;
        if (len_left == 2'd1) begin
          phase_next = PH_TAG1;
        end
      end
      PH_TAG1: begin
        tag_acc_next = {{(TagW-ByteW){1'b0}}, data_byte};
        if ((data_byte & TagMoreMask) == TagMoreMask) begin
          phase_next = PH_TAG2;
        end else begin
          phase_next = PH_ILEN1;
        end
      end
      PH_TAG2: begin
        tag_acc_next = {tag_acc[TagW-ByteW-1:0], data_byte};
        if ((data_byte & TagContMask) == TagContMask) begin
          phase_next = PH_TAG3;
        end else begin
          phase_next = PH_ILEN1;
        end
      end
      PH_TAG3: begin
        tag_acc_next = {tag_acc[TagW-ByteW-1:0], data_byte};
        phase_next   = PH_ILEN1;
      end
      PH_ILEN1: begin
        if (data_byte <= ShortLenMax) begin
          len_val      = {{(LenW-ByteW){1'b0}}, data_byte};
          len_acc_next = len_val;
          len_done     = 1'b1;
        end else if (data_byte == LongLen1 || data_byte == LongLen2) begin
          len_acc_next  = '0;
          len_left_next = (data_byte == LongLen1) ? 2'd1 : 2'd2;
          phase_next    = PH_ILEN_MORE;
        end else begin
          phase_next = PH_STOP;
        end
      end
      PH_ILEN_MORE: begin
        len_val       = {len_acc[ByteW-1:0], data_byte};
        len_acc_next  = len_val;
        len_left_next = len_left - 2'd1;
        len_done      = (len_left == 2'd1);
      end
      PH_SKIP, PH_SKIP_CAND: begin
        skip_left_next = skip_left - 1'b1;
        if (skip_left == {{(LenW-1){1'b0}}, 1'b1}) begin
          if (phase == PH_SKIP_CAND) begin
            match_latched_next = 1'b1;
          end
          phase_next = PH_TAG1;
        end
      end
      default: begin
      end
    endcase

    // inner length complete: candidate check and value skip
    if (len_done) begin
      cand = !match_latched && (tag_acc == target_tag);
      if (cand) begin
        match_tag_next = tag_acc;
        match_len_next = len_val;
        if (len_val == '0) begin
          match_off_next     = '0;
          match_latched_next = 1'b1;
        end else begin
          match_off_next = pos_inc;
        end
      end
      if (len_val == '0) begin
        phase_next = PH_TAG1;
      end else begin
        skip_left_next = len_val;
        phase_next     = cand ? PH_SKIP_CAND : PH_SKIP;
      end
    end
  end

  // final status, by priority
  always_comb begin
    if (fault_next == HF_TEMPLATE) begin
      status_next = ST_WRONG_TMPL;
    end else if (fault_next == HF_OUTER_LEN || phase_next == PH_TMPL ||
                 phase_next == PH_OLEN1 || phase_next == PH_OLEN_MORE) begin
      status_next = ST_BAD_OUTER;
    end else if (fault_next == HF_EXCESS || outer_len_next != '0) begin
      status_next = ST_LEN_MISMATCH;
    end else if (match_latched_next) begin
      status_next = ST_FOUND;
    end else begin
      status_next = ST_NOT_FOUND;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      template_tag <= TemplateTagRst;
      target_tag   <= TargetTagRst;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegTemplateTag: template_tag <= cfg_data[ByteW-1:0];
        RegTargetTag:   target_tag   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // parse state registers; a last byte starts a fresh message
  always_ff @(posedge clk) begin
    if (rst || (in_accept && last_byte)) begin
      phase         <= PH_TMPL;
      fault         <= HF_NONE;
      byte_pos      <= '0;
      outer_len     <= '0;
      tag_acc       <= '0;
      len_acc       <= '0;
      len_left      <= '0;
      skip_left     <= '0;
      match_latched <= 1'b0;
      match_tag     <= '0;
      match_off     <= '0;
      match_len     <= '0;
    end else if (in_accept) begin
      phase         <= phase_next;
      fault         <= fault_next;
      byte_pos      <= byte_pos_next;
      outer_len     <= outer_len_next;
      tag_acc       <= tag_acc_next;
      len_acc       <= len_acc_next;
      len_left      <= len_left_next;
      skip_left     <= skip_left_next;
      match_latched <= match_latched_next;
      match_tag     <= match_tag_next;
      match_off     <= match_off_next;
      match_len     <= match_len_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last_byte) begin
      status <= status_next;
      if (status_next == ST_FOUND) begin
        found_tag    <= match_tag_next;
        value_offset <= match_off_next;
        value_length <= match_len_next;
      end else begin
        found_tag    <= '0;
        value_offset <= '0;
        value_length <= '0;
      end
    end
  end

`ifndef SYNTH
  // input is held off only while a result waits
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // a last byte always returns the parser to the template phase
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_byte |=> phase == PH_TMPL && byte_pos == '0 && !match_latched)
    else $error("parse state not cleared after last byte");

  // a result beat follows every accepted last byte
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_byte |=> out_valid)
    else $error("no result after last byte");

  // result fields are zero unless found
  a_zero_unless_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FOUND |->
      found_tag == '0 && value_offset == '0 && value_length == '0)
    else $error("nonzero fields on a miss");

  // a zero-length match has a zero offset
  a_zero_len_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FOUND && value_length == '0 |-> value_offset == '0)
    else $error("offset set for empty value");
`endif

endmodule
